@@ rtl/dkef_pkg.sv @@
// Shared constants, codes and types of the debounced key event FIFO.
package dkef_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int FIFO_DEPTH  = 128;
    localparam int NUM_ID_REGS = 4;

    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int KEY_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ID_SEL_W  = 2;
    localparam int TICK_W    = 16;
    localparam int ID_W      = 8;
    localparam int CODE_W    = 16;
    localparam int CMD_W     = 2;
    localparam int KIDX_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ID0  = 3'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_EDGE = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic             edge_we;
        logic [KEY_W-1:0] key;
        logic             level;
        logic             tick;
    } t_tmr_ctrl;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             level;
    } t_push;

endpackage

@@ rtl/dkef_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dkef_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dkef_fifo.sv @@
// Ring FIFO of event codes with read and write pointers over a RAM.
module dkef_fifo
    import dkef_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_pop,
    output logic [CODE_W-1:0] o_rdata,
    output logic              o_empty,
    output logic              o_full
);

    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] n_rd;
    logic [PTR_W-1:0] n_wr;
    logic             w_we;

    assign n_wr    = (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign o_empty = (r_wr == r_rd);
    assign o_full  = (n_wr == r_rd);
    assign w_we    = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            if (w_we) begin
                r_wr <= n_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= n_rd;
            end
        end
    end

    dkef_ram #(
        .WIDTH(CODE_W),
        .DEPTH(FIFO_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_wr),
        .i_wdata(i_code),
        .i_re   (i_pop),
        .i_raddr(r_rd),
        .o_rdata(o_rdata)
    );

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd < PTR_W'(FIFO_DEPTH - 1) || r_rd == PTR_W'(FIFO_DEPTH - 1)) &&
        (r_wr < PTR_W'(FIFO_DEPTH - 1) || r_wr == PTR_W'(FIFO_DEPTH - 1)))
        else $error("FIFO pointer beyond depth");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && i_push && !i_pop) |=> $stable(r_wr))
        else $error("write pointer moved on a push while full");

endmodule

@@ rtl/dkef_timer_scan.sv @@
// Per-key debounce timers scanned one key per cycle through a shared decrementer.
module dkef_timer_scan
    import dkef_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tmr_ctrl         i_ctrl,
    input  logic [TICK_W-1:0] i_ticks,
    output t_push             o_push,
    output logic              o_done
);

    logic [TICK_W-1:0] r_count [NUM_KEYS];
    logic              r_level [NUM_KEYS];
    logic              r_busy;
    logic [KEY_W-1:0]  r_idx;
    logic [TICK_W-1:0] w_cur;
    logic [TICK_W-1:0] n_count;
    logic [TICK_W-1:0] w_load;

    assign w_cur   = r_count[r_idx];
    assign n_count = w_cur - 1'b1;
    assign w_load  = (i_ticks == '0) ? TICK_W'(1) : i_ticks;

    assign o_push.valid = r_busy && (w_cur == TICK_W'(1));
    assign o_push.key   = r_idx;
    assign o_push.level = r_level[r_idx];
    assign o_done       = r_busy && (r_idx == KEY_W'(NUM_KEYS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_count[k] <= '0;
                r_level[k] <= 1'b0;
            end
        end else begin
            if (i_ctrl.edge_we) begin
                r_count[i_ctrl.key] <= w_load;
                r_level[i_ctrl.key] <= i_ctrl.level;
            end
            if (i_ctrl.tick) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (w_cur != '0) begin
                    r_count[r_idx] <= n_count;
                end
                if (o_done) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/debounced_key_event_fifo.sv @@
// Top level: key debounce timers feeding an event code FIFO over stream ports.
// Each accepted word steps from S_IDLE to S_DONE and then into the output register:
// an edge goes straight to S_DONE, a tick through S_SCAN, where the timer scan visits
// one key per cycle through one decrementer, and a read of a non-empty FIFO through S_READ
// for the registered RAM read. Words are accepted only in S_IDLE; S_DONE waits on a full output.
// Synchronous active-low reset clears timers, levels and pointers and reloads register defaults.
module debounced_key_event_fifo
    import dkef_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [1:0] command, [3:2] key_index, [4] key_level, [7:5] zero
    input  logic [S_DATA_W-1:0]  i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [15:0] read_code, [16] read_valid, [17] events_pending, [23:18] zero
    output logic [M_DATA_W-1:0]  o_m_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [TICK_W-1:0] r_ticks;
    logic [ID_W-1:0]   r_key_id [NUM_ID_REGS];
    logic [CODE_W-1:0] r_code;
    logic              r_rv;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_rv;
    logic              r_out_pend;

    t_cmd              w_cmd;
    logic [KIDX_W-1:0] w_kidx;
    logic              w_level;
    logic              w_accept;
    logic              w_out_free;
    t_tmr_ctrl         w_ctrl;
    t_push             w_push;
    logic              w_done;
    logic [CODE_W-1:0] w_push_code;
    logic [CODE_W-1:0] w_rdata;
    logic              w_empty;
    logic              w_full;
    logic              w_pop;

    assign w_cmd      = t_cmd'(i_s_tdata[1:0]);
    assign w_kidx     = i_s_tdata[3:2];
    assign w_level    = i_s_tdata[4];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign w_ctrl.edge_we = w_accept && (w_cmd == CMD_EDGE) &&
                            ({1'b0, w_kidx} < 3'(NUM_KEYS));
    assign w_ctrl.key     = KEY_W'(w_kidx);
    assign w_ctrl.level   = w_level;
    assign w_ctrl.tick    = w_accept && (w_cmd == CMD_TICK);
    assign w_pop          = w_accept && (w_cmd == CMD_READ) && !w_empty;

    assign w_push_code = {r_key_id[ID_SEL_W'(w_push.key)], 7'd0, w_push.level};

    dkef_timer_scan u_timer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl),
        .i_ticks(r_ticks),
        .o_push (w_push),
        .o_done (w_done)
    );

    dkef_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push.valid),
        .i_code (w_push_code),
        .i_pop  (w_pop),
        .o_rdata(w_rdata),
        .o_empty(w_empty),
        .o_full (w_full)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ticks     <= TICKS_RESET;
            for (int i = 0; i < NUM_ID_REGS; i++) begin
                r_key_id[i] <= ID_W'(i);
            end
            r_code      <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_code  <= '0;
            r_out_rv    <= 1'b0;
            r_out_pend  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DEBOUNCE) begin
                    r_ticks <= i_cfg_data;
                end else if (i_cfg_index < CFG_KEY_ID0 + CFG_IDX_W'(NUM_ID_REGS)) begin
                    r_key_id[ID_SEL_W'(i_cfg_index - CFG_KEY_ID0)] <= i_cfg_data[ID_W-1:0];
                end
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_code <= '0;
                        r_rv   <= 1'b0;
                        case (w_cmd)
                            CMD_TICK: r_state <= S_SCAN;
                            CMD_READ: r_state <= w_empty ? S_DONE : S_READ;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_code  <= w_rdata;
                    r_rv    <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_code  <= r_code;
                        r_out_rv    <= r_rv;
                        r_out_pend  <= !w_empty;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_pend, r_out_rv, r_out_code};

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_rv) |-> (r_out_code == '0))
        else $error("code word without a pop carries a nonzero code");

    a_push_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> (r_state == S_SCAN))
        else $error("timer push outside a tick scan");

    a_pop_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == S_READ))
        else $error("FIFO pop not followed by the read data cycle");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_empty)
        else $error("FIFO reports full and empty at once");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the debounced key event FIFO with a scoreboard predictor.
module tb_top;
    import dkef_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = NUM_KEYS + 6;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic              events_pending;
        logic              read_valid;
        logic [CODE_W-1:0] read_code;
    } t_key_result;

    class key_event_scoreboard;
        logic [TICK_W-1:0] debounce_ticks;
        logic [ID_W-1:0]   key_id [NUM_ID_REGS];
        logic              key_level [NUM_KEYS];
        logic [TICK_W-1:0] ticks_left [NUM_KEYS];
        logic [CODE_W-1:0] code_ring [FIFO_DEPTH];
        logic [PTR_W-1:0]  rd_ptr;
        logic [PTR_W-1:0]  wr_ptr;
        t_key_result       expected_words [$];
        int                mismatches;

        function new();
            debounce_ticks = TICKS_RESET;
            for (int k = 0; k < NUM_ID_REGS; k++) begin
                key_id[k] = ID_W'(k);
            end
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_level[k] = 1'b0;
                ticks_left[k] = '0;
            end
            rd_ptr     = '0;
            wr_ptr     = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_DEBOUNCE) begin
                debounce_ticks = val[TICK_W-1:0];
            end else if (idx >= CFG_KEY_ID0 && idx < CFG_KEY_ID0 + NUM_ID_REGS) begin
                key_id[ID_SEL_W'(idx - CFG_KEY_ID0)] = val[ID_W-1:0];
            end
        endfunction

        function void push_code(logic [CODE_W-1:0] code);
            logic [PTR_W-1:0] nxt;
            nxt = wr_ptr + 1'b1;
            if (nxt != rd_ptr) begin
                code_ring[wr_ptr] = code;
                wr_ptr = nxt;
            end
        endfunction

        function void note_item(logic [S_DATA_W-1:0] w);
            t_cmd              cmd;
            logic [KIDX_W-1:0] kidx;
            logic              lvl;
            t_key_result       res;
            cmd  = t_cmd'(w[CMD_W-1:0]);
            kidx = w[CMD_W +: KIDX_W];
            lvl  = w[CMD_W + KIDX_W];
            res  = '0;
            case (cmd)
                CMD_TICK: begin
                    for (int k = 0; k < NUM_KEYS; k++) begin
                        if (ticks_left[k] != 0) begin
                            ticks_left[k] = ticks_left[k] - 1'b1;
                            if (ticks_left[k] == 0) begin
                                push_code({key_id[k], 7'b0, key_level[k]});
                            end
                        end
                    end
                end
                CMD_EDGE: begin
                    if (kidx < NUM_KEYS) begin
                        key_level[kidx] = lvl;
                        ticks_left[kidx] = (debounce_ticks == 0) ? TICK_W'(1) : debounce_ticks;
                    end
                end
                CMD_READ: begin
                    if (rd_ptr != wr_ptr) begin
                        res.read_code  = code_ring[rd_ptr];
                        res.read_valid = 1'b1;
                        rd_ptr = rd_ptr + 1'b1;
                    end
                end
                default: begin
                end
            endcase
            res.events_pending = (rd_ptr != wr_ptr);
            expected_words.push_back(res);
        endfunction

        function void check_word(logic [M_DATA_W-1:0] w);
            t_key_result got;
            t_key_result want;
            got = w[$bits(t_key_result)-1:0];
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: unexpected word %h", w);
                end
                return;
            end
            want = expected_words.pop_front();
            if (got.read_code !== want.read_code || got.read_valid !== want.read_valid ||
                got.events_pending !== want.events_pending) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: code %h/%h valid %b/%b pending %b/%b (exp/act)",
                             want.read_code, got.read_code, want.read_valid,
                             got.read_valid, want.events_pending, got.events_pending);
                end
            end
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    key_event_scoreboard sb;
    int sender_gap_pct = 9;
    int receiver_stall_pct = 62;
    int quiet_cycles = 0;

    debounced_key_event_fifo i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_word(o_m_tdata);
        end
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(t_cmd c, logic [KIDX_W-1:0] k, logic l);
        return {{(S_DATA_W - CMD_W - KIDX_W - 1){1'b0}}, l, k, c};
    endfunction

    task automatic send_word(input logic [S_DATA_W-1:0] w);
        if ($urandom_range(99) < sender_gap_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_gap_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(w);
    endtask

    task automatic wait_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [TICK_W-1:0] ticks,
                                 input logic [NUM_ID_REGS*ID_W-1:0] ids);
        write_reg(CFG_DEBOUNCE, ticks);
        for (int k = 0; k < NUM_ID_REGS; k++) begin
            write_reg(CFG_KEY_ID0 + CFG_IDX_W'(k), CFG_DAT_W'(ids[k*ID_W +: ID_W]));
        end
    endtask

    task automatic run_phase(input int n_items, input int read_pct, input int edge_pct);
        t_cmd c;
        int   r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < read_pct) begin
                c = CMD_READ;
            end else if (r < read_pct + 3) begin
                c = CMD_NOP;
            end else if ($urandom_range(99) < edge_pct) begin
                c = CMD_EDGE;
            end else begin
                c = CMD_TICK;
            end
            send_word(pack_item(c, KIDX_W'($urandom_range(NUM_KEYS - 1)),
                                1'($urandom_range(1))));
            if ($urandom_range(59) == 0) begin
                wait_until_drained();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_settings(16'd1, {8'h5A, 8'hA5, 8'hFF, 8'h00});
        send_word(pack_item(CMD_READ, 2'd0, 1'b0));
        send_word(pack_item(CMD_NOP, 2'd3, 1'b1));
        send_word(pack_item(CMD_EDGE, 2'd0, 1'b1));
        send_word(pack_item(CMD_EDGE, 2'd1, 1'b0));
        send_word(pack_item(CMD_EDGE, 2'd2, 1'b1));
        send_word(pack_item(CMD_EDGE, 2'd3, 1'b1));
        send_word(pack_item(CMD_TICK, 2'd0, 1'b0));
        repeat (5) send_word(pack_item(CMD_READ, 2'd0, 1'b0));
        send_word(pack_item(CMD_EDGE, 2'd3, 1'b0));
        send_word(pack_item(CMD_EDGE, 2'd3, 1'b1));
        send_word(pack_item(CMD_TICK, 2'd2, 1'b1));
        send_word(pack_item(CMD_READ, 2'd1, 1'b1));
        wait_until_drained();

        write_reg(CFG_DEBOUNCE, '0);
        send_word(pack_item(CMD_EDGE, 2'd0, 1'b0));
        send_word(pack_item(CMD_EDGE, 2'd1, 1'b1));
        send_word(pack_item(CMD_TICK, 2'd0, 1'b0));
        send_word(pack_item(CMD_TICK, 2'd0, 1'b0));
        repeat (3) send_word(pack_item(CMD_READ, 2'd0, 1'b0));
        wait_until_drained();

        // The first phase rarely reads, so the ring fills and later codes are dropped.
        load_settings(16'd1, {8'h7F, 8'h80, 8'h00, 8'hFF});
        run_phase(300, 2, 66);
        wait_until_drained();
        load_settings(16'd3, 32'($urandom));
        run_phase(150, 60, 40);
        wait_until_drained();

        sender_gap_pct = 62;
        receiver_stall_pct = 9;
        write_reg(CFG_DEBOUNCE, '0);
        run_phase(120, 30, 50);
        wait_until_drained();
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        run_phase(40, 30, 50);
        wait_until_drained();

        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        load_settings(16'd2, {8'hC3, 8'h3C, 8'hFF, 8'h00});
        run_phase(200, 25, 50);
        wait_until_drained();

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ debounced_key_event_fifo.f @@
rtl/dkef_pkg.sv
rtl/dkef_ram.sv
rtl/dkef_fifo.sv
rtl/dkef_timer_scan.sv
rtl/debounced_key_event_fifo.sv
dv/tb_top.sv
